### rtl/aes128_cbc_cipher_defines.svh
// Assertion macros for the AES-128 CBC block.
`ifndef AES128_CBC_CIPHER_DEFINES_SVH
`define AES128_CBC_CIPHER_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define AES_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define AES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### rtl/aes_pkg.sv
// Shared types, constants and round functions for the AES-128 CBC block.
package aes_pkg;

    localparam int ROUND_COUNT = 10;
    localparam int RND_W       = $clog2(ROUND_COUNT + 1);

    localparam logic [2:0] REG_KEY_HIGH = 3'd0;
    localparam logic [2:0] REG_KEY_LOW  = 3'd1;
    localparam logic [2:0] REG_IV_HIGH  = 3'd2;
    localparam logic [2:0] REG_IV_LOW   = 3'd3;
    localparam logic [2:0] REG_DECRYPT  = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_LOAD,
        ST_ROUND
    } state_t;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    function automatic logic [7:0] inv_sub_byte(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        return t[x];
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte i of a 128-bit value; byte 0 is the top byte.
    function automatic logic [7:0] byte_of(input logic [127:0] s, input int i);
        return s[127 - 8*i -: 8];
    endfunction

    function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3;
        logic [127:0] o;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[r + 4*c] = sbox(byte_of(s, r + 4*((c + r) & 3)));
        for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            if (!last) begin
                t[4*c]   = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
                t[4*c+1] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
                t[4*c+2] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
                t[4*c+3] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
            end
        end
        for (int i = 0; i < 16; i++) o[127 - 8*i -: 8] = t[i];
        return o;
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] m);
        logic [7:0] a2, a4, a8;
        a2 = xt(a); a4 = xt(a2); a8 = xt(a4);
        return (m[0] ? a : 8'h00) ^ (m[1] ? a2 : 8'h00) ^ (m[2] ? a4 : 8'h00)
            ^ (m[3] ? a8 : 8'h00);
    endfunction

    // Inverse shift and substitution.
    function automatic logic [127:0] dec_sub(input logic [127:0] s);
        logic [127:0] o;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                o[127 - 8*(r + 4*((c + r) & 3)) -: 8] = inv_sub_byte(byte_of(s, r + 4*c));
        return o;
    endfunction

    function automatic logic [127:0] inv_mix(input logic [127:0] s);
        logic [7:0] a0, a1, a2, a3;
        logic [127:0] o;
        for (int c = 0; c < 4; c++) begin
            a0 = byte_of(s, 4*c); a1 = byte_of(s, 4*c+1);
            a2 = byte_of(s, 4*c+2); a3 = byte_of(s, 4*c+3);
            o[127 - 32*c -: 8]  = gmul(a0,4'he)^gmul(a1,4'hb)^gmul(a2,4'hd)^gmul(a3,4'h9);
            o[119 - 32*c -: 8]  = gmul(a0,4'h9)^gmul(a1,4'he)^gmul(a2,4'hb)^gmul(a3,4'hd);
            o[111 - 32*c -: 8]  = gmul(a0,4'hd)^gmul(a1,4'h9)^gmul(a2,4'he)^gmul(a3,4'hb);
            o[103 - 32*c -: 8]  = gmul(a0,4'hb)^gmul(a1,4'hd)^gmul(a2,4'h9)^gmul(a3,4'he);
        end
        return o;
    endfunction

    // One key schedule step: next round key from the previous one.
    function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] t, w0, w1, w2, w3;
        t = {sbox(k[23:16]), sbox(k[15:8]), sbox(k[7:0]), sbox(k[31:24])};
        t = t ^ {rc, 24'h0};
        w0 = k[127:96] ^ t;
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

### rtl/aes_key_ram.sv
// Round-key store: 128-bit entries, one write and one registered read port.
module aes_key_ram (
    input  logic                       clk,
    input  logic                       we,
    input  logic [aes_pkg::RND_W-1:0]  waddr,
    input  logic [127:0]               wdata,
    input  logic [aes_pkg::RND_W-1:0]  raddr,
    output logic [127:0]               rdata
);
    logic [127:0] mem [aes_pkg::ROUND_COUNT + 1];

    // Write a round key
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Register the read data
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end
endmodule

### rtl/aes128_cbc_cipher.sv
// Top level of the AES-128 CBC cipher block.
// Usage:
//  Write key_high/key_low (0,1), iv_high/iv_low (2,3), decrypt_mode (4) on the
//  cfg port while idle. Send blocks on the in channel (block_high, block_low,
//  start_of_message); results leave on the out channel (out_high, out_low).
//  start_of_message reloads the chain value from the IV before the block.
//  Per block: the key is expanded into the round-key RAM, the first RAM read
//  is primed, then the round keys are added and the ten rounds run; the result
//  is registered. The key RAM has one read port and is read one round key per
//  cycle, held at the last round while the output register is busy; a new
//  block is taken only in idle, once the last result has gone to the output.
//  Reset clears the chain value and configuration registers to zero; the key
//  RAM needs no clearing since it is filled before every block. A stalled
//  receiver holds the result in the output register; the next block is still
//  taken and processed, then waits at its last round with in_ready low.
//  Chaining: encrypt out = E(in ^ chain), chain = out;
//  decrypt out = D(in) ^ chain, chain = in.
`include "aes128_cbc_cipher_defines.svh"
module aes128_cbc_cipher (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [63:0]  block_high,
    input  logic [63:0]  block_low,
    input  logic         start_of_message,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [63:0]  out_high,
    output logic [63:0]  out_low
);
    logic [127:0] key_reg, iv_reg, chain_reg, chain_next, st_reg, st_next;
    logic [127:0] kx_reg, kx_next, blk_reg, blk_next, ram_rd, res_reg, res_next;
    logic         dec_reg;
    logic         ov_reg, ov_next;
    logic [7:0]   rc_reg, rc_next;
    logic [aes_pkg::RND_W-1:0] cnt_reg, cnt_next, raddr;
    aes_pkg::state_t state_reg, state_next;
    logic         ram_we;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
            iv_reg  <= '0;
            dec_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                aes_pkg::REG_KEY_HIGH: key_reg[127:64] <= cfg_data;
                aes_pkg::REG_KEY_LOW:  key_reg[63:0]   <= cfg_data;
                aes_pkg::REG_IV_HIGH:  iv_reg[127:64]  <= cfg_data;
                aes_pkg::REG_IV_LOW:   iv_reg[63:0]    <= cfg_data;
                aes_pkg::REG_DECRYPT:  dec_reg         <= cfg_data[0];
                default: ;
            endcase
        end
    end

    aes_key_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg),
        .wdata (kx_reg),
        .raddr (raddr),
        .rdata (ram_rd)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= aes_pkg::ST_IDLE;
            chain_reg <= '0;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            chain_reg <= chain_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        st_reg  <= st_next;
        kx_reg  <= kx_next;
        blk_reg <= blk_next;
        rc_reg  <= rc_next;
        res_reg <= res_next;
    end

    // Sequence expansion, then the rounds
    always_comb
    begin
        state_next = state_reg;
        chain_next = chain_reg;
        cnt_next   = cnt_reg;
        st_next    = st_reg;
        kx_next    = kx_reg;
        blk_next   = blk_reg;
        rc_next    = rc_reg;
        res_next   = res_reg;
        ov_next    = ov_reg && !out_ready;
        ram_we     = 1'b0;
        raddr      = dec_reg ? aes_pkg::RND_W'(aes_pkg::ROUND_COUNT) : '0;
        in_ready   = 1'b0;
        case (state_reg)
            aes_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    blk_next = {block_high, block_low};
                    if (start_of_message)
                        chain_next = iv_reg;
                    kx_next   = key_reg;
                    rc_next   = 8'h01;
                    cnt_next  = '0;
                    state_next = aes_pkg::ST_EXPAND;
                end
            end
            aes_pkg::ST_EXPAND:
            begin
                // write current key, derive the next
                ram_we  = 1'b1;
                kx_next = aes_pkg::key_step(kx_reg, rc_reg);
                rc_next = aes_pkg::xt(rc_reg);
                if (cnt_reg == aes_pkg::RND_W'(aes_pkg::ROUND_COUNT))
                    state_next = aes_pkg::ST_LOAD;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            aes_pkg::ST_LOAD:
            begin
                // read of first round key is in flight
                st_next  = dec_reg ? blk_reg : (blk_reg ^ chain_reg);
                cnt_next = '0;
                raddr    = dec_reg ? aes_pkg::RND_W'(aes_pkg::ROUND_COUNT) : '0;
                state_next = aes_pkg::ST_ROUND;
            end
            aes_pkg::ST_ROUND:
            begin
                // on the last round keep reading the same key while the result waits
                if (cnt_reg == aes_pkg::RND_W'(aes_pkg::ROUND_COUNT))
                    raddr = dec_reg ? '0 : aes_pkg::RND_W'(aes_pkg::ROUND_COUNT);
                else
                    raddr = dec_reg ? aes_pkg::RND_W'(aes_pkg::ROUND_COUNT - 1) - cnt_reg
                                    : cnt_reg + 1'b1;
                if (dec_reg)
                begin
                    if (cnt_reg == '0)
                        st_next = aes_pkg::dec_sub(st_reg ^ ram_rd);
                    else if (cnt_reg == aes_pkg::RND_W'(aes_pkg::ROUND_COUNT))
                        st_next = st_reg ^ ram_rd;
                    else
                        st_next = aes_pkg::dec_sub(aes_pkg::inv_mix(st_reg ^ ram_rd));
                end
                else
                begin
                    if (cnt_reg == aes_pkg::RND_W'(aes_pkg::ROUND_COUNT))
                        st_next = st_reg ^ ram_rd;
                    else
                        st_next = aes_pkg::enc_round(st_reg ^ ram_rd,
                            cnt_reg == aes_pkg::RND_W'(aes_pkg::ROUND_COUNT - 1));
                end
                if (cnt_reg == aes_pkg::RND_W'(aes_pkg::ROUND_COUNT))
                begin
                    // load the output register once it is free or leaving
                    if (!ov_reg || out_ready)
                    begin
                        res_next   = dec_reg ? (st_next ^ chain_reg) : st_next;
                        chain_next = dec_reg ? blk_reg : st_next;
                        ov_next    = 1'b1;
                        state_next = aes_pkg::ST_IDLE;
                    end
                    else
                        st_next = st_reg;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            default: state_next = aes_pkg::ST_IDLE;
        endcase
    end

    assign out_valid = ov_reg;
    assign out_high  = res_reg[127:64];
    assign out_low   = res_reg[63:0];

    `AES_ASSERT_NEXT(a_vhold, clk, rst_n, out_valid && !out_ready, out_valid)
    `AES_ASSERT_NEXT(a_start, clk, rst_n, in_valid && in_ready,
        state_reg == aes_pkg::ST_EXPAND)
    `AES_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, $stable(res_reg))
endmodule

### sim/tb_top.sv
// Testbench for the AES-128 CBC cipher: queue-fed driver, monitor and scoreboard.
module tb_top;

    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
        logic        som;
    } blk_t;

    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
    } res_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        start_of_message;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] out_high;
    logic [63:0] out_low;

    aes128_cbc_cipher u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .block_high(block_high), .block_low(block_low),
        .start_of_message(start_of_message),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_high(out_high), .out_low(out_low)
    );

    // cipher model state
    logic [127:0] mdl_key;
    logic [127:0] mdl_iv;
    logic         mdl_dec;
    logic [127:0] mdl_chain;
    logic [7:0]   fwd_tab [256];
    logic [7:0]   inv_tab [256];

    blk_t pending_blocks[$];
    res_t expected_blocks[$];
    int   errors;
    bit   quiet;
    bit   hold_req;
    bit   hold_on;
    bit   in_ready_seen;
    int   in_gap;
    int   out_gap;

    always #10 clk = ~clk;

    function automatic logic [7:0] gdbl(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gprod(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p ^= a;
            a = gdbl(a);
        end
        return p;
    endfunction

    // build the S-box from the multiplicative inverse and affine map
    task automatic build_tables();
        logic [7:0] iv;
        logic [7:0] s;
        for (int x = 0; x < 256; x++) begin
            iv = 0;
            for (int y = 1; y < 256; y++)
                if (gprod(8'(x), 8'(y)) == 8'h01) iv = 8'(y);
            s = iv ^ {iv[6:0], iv[7]} ^ {iv[5:0], iv[7:6]} ^ {iv[4:0], iv[7:5]}
                ^ {iv[3:0], iv[7:4]} ^ 8'h63;
            fwd_tab[x] = s;
            inv_tab[s] = 8'(x);
        end
    endtask

    function automatic logic [7:0] bget(input logic [127:0] v, input int i);
        return v[127 - 8*i -: 8];
    endfunction

    function automatic logic [127:0] run_cipher(input logic [127:0] din, input logic dec);
        logic [127:0] rk [11];
        logic [31:0]  w [44];
        logic [31:0]  t;
        logic [7:0]   rc;
        logic [7:0]   s [16];
        logic [7:0]   u [16];
        logic [7:0]   a [4];
        logic [7:0]   m [4];
        logic [127:0] o;
        int r;
        rc = 8'h01;
        for (int i = 0; i < 4; i++) w[i] = mdl_key[127 - 32*i -: 32];
        for (int i = 4; i < 44; i++) begin
            t = w[i-1];
            if (i % 4 == 0) begin
                t = {t[23:0], t[31:24]};
                t = {fwd_tab[t[31:24]], fwd_tab[t[23:16]], fwd_tab[t[15:8]], fwd_tab[t[7:0]]};
                t ^= {rc, 24'h0};
                rc = gdbl(rc);
            end
            w[i] = w[i-4] ^ t;
        end
        for (int k = 0; k < 11; k++) rk[k] = {w[4*k], w[4*k+1], w[4*k+2], w[4*k+3]};
        if (dec) begin
            m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
            for (int i = 0; i < 16; i++) s[i] = bget(din, i) ^ bget(rk[10], i);
            for (r = 9; r >= 0; r--) begin
                for (int c = 0; c < 4; c++)
                    for (int q = 0; q < 4; q++) u[q + 4*((c+q) & 3)] = s[q + 4*c];
                for (int i = 0; i < 16; i++) s[i] = inv_tab[u[i]] ^ bget(rk[r], i);
                if (r > 0)
                    for (int c = 0; c < 4; c++) begin
                        for (int q = 0; q < 4; q++) a[q] = s[4*c+q];
                        for (int q = 0; q < 4; q++)
                            s[4*c+q] = gprod(a[0], m[(4-q)&3]) ^ gprod(a[1], m[(5-q)&3])
                                ^ gprod(a[2], m[(6-q)&3]) ^ gprod(a[3], m[(7-q)&3]);
                    end
            end
        end else begin
            m = '{8'h02, 8'h03, 8'h01, 8'h01};
            for (int i = 0; i < 16; i++) s[i] = bget(din, i) ^ bget(rk[0], i);
            for (r = 1; r <= 10; r++) begin
                for (int c = 0; c < 4; c++)
                    for (int q = 0; q < 4; q++) u[q + 4*c] = fwd_tab[s[q + 4*((c+q) & 3)]];
                s = u;
                if (r < 10)
                    for (int c = 0; c < 4; c++) begin
                        for (int q = 0; q < 4; q++) a[q] = s[4*c+q];
                        for (int q = 0; q < 4; q++)
                            s[4*c+q] = gprod(a[0], m[(4-q)&3]) ^ gprod(a[1], m[(5-q)&3])
                                ^ gprod(a[2], m[(6-q)&3]) ^ gprod(a[3], m[(7-q)&3]);
                    end
                for (int i = 0; i < 16; i++) s[i] ^= bget(rk[r], i);
            end
        end
        for (int i = 0; i < 16; i++) o[127 - 8*i -: 8] = s[i];
        return o;
    endfunction

    // chain one accepted block through the model and queue its result
    task automatic predict_block(input blk_t b);
        logic [127:0] din;
        logic [127:0] o;
        res_t e;
        din = {b.hi, b.lo};
        if (b.som) mdl_chain = mdl_iv;
        if (mdl_dec) begin
            o = run_cipher(din, 1'b1) ^ mdl_chain;
            mdl_chain = din;
        end else begin
            o = run_cipher(din ^ mdl_chain, 1'b0);
            mdl_chain = o;
        end
        e.hi = o[127:64];
        e.lo = o[63:0];
        expected_blocks.push_back(e);
    endtask

    // register write at one rising edge, mirrored into the model
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            aes_pkg::REG_KEY_HIGH: mdl_key[127:64] = val;
            aes_pkg::REG_KEY_LOW:  mdl_key[63:0] = val;
            aes_pkg::REG_IV_HIGH:  mdl_iv[127:64] = val;
            aes_pkg::REG_IV_LOW:   mdl_iv[63:0] = val;
            aes_pkg::REG_DECRYPT:  mdl_dec = val[0];
            default: ;
        endcase
    endtask

    // check at rising edges, where the driver's updates have settled
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_blocks.size() != 0 || expected_blocks.size() != 0 || in_valid);
        repeat (30) @(negedge clk);
    endtask

    function automatic logic [63:0] rnd64();
        case ($urandom_range(0, 7))
            0: return 64'h0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic blk_t mk_blk(input logic [63:0] h, input logic [63:0] l,
                                    input logic som);
        blk_t b;
        b.hi = h;
        b.lo = l;
        b.som = som;
        return b;
    endfunction

    // driver: present queued blocks, idle in random bursts
    always @(negedge clk) begin
        bit go;
        bit waiting;
        go = 1'b0;
        waiting = in_valid && !in_ready_seen;
        if (rst_n) begin
            if (waiting) begin
                // hold the offered block until it is transferred
            end else if (in_gap > 0) begin
                in_gap <= in_gap - 1;
            end else if (pending_blocks.size() != 0) begin
                if (!quiet && $urandom_range(0, 5) == 0)
                    in_gap <= $urandom_range(0, 8);
                else
                    go = 1'b1;
            end
            if (go) begin
                in_valid <= 1'b1;
                {block_high, block_low, start_of_message} <=
                    {pending_blocks[0].hi, pending_blocks[0].lo, pending_blocks[0].som};
                void'(pending_blocks.pop_front());
            end else if (!waiting) begin
                in_valid <= 1'b0;
            end
        end
    end

    // record transfers at the rising edge
    always @(posedge clk) begin
        in_ready_seen <= rst_n && in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
            predict_block(mk_blk(block_high, block_low, start_of_message));
    end

    // long receiver hold-off, counted in cycles here
    initial begin
        hold_on = 1'b0;
        wait (hold_req);
        hold_on = 1'b1;
        repeat (400) @(posedge clk);
        hold_on = 1'b0;
    end

    // receiver stall bursts
    always @(negedge clk) begin
        if (rst_n) begin
            if (hold_on) begin
                out_ready <= 1'b0;
            end else if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                out_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                out_gap <= $urandom_range(0, 8);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // compare each result transfer with the oldest expectation
    always @(posedge clk) begin
        res_t e;
        if (rst_n && out_valid && out_ready) begin
            if (expected_blocks.size() == 0) begin
                $display("%0t: unexpected result hi=%h lo=%h", $time, out_high, out_low);
                errors++;
            end else begin
                e = expected_blocks.pop_front();
                if (out_high !== e.hi) begin
                    $display("%0t: out_high expected %h actual %h", $time, e.hi, out_high);
                    errors++;
                end
                if (out_low !== e.lo) begin
                    $display("%0t: out_low expected %h actual %h", $time, e.lo, out_low);
                    errors++;
                end
            end
        end
    end

    initial begin
        #50_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int n_msg;
        clk = 0;
        rst_n = 0;
        cfg_we = 0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 0;
        block_high = '0;
        block_low = '0;
        start_of_message = 0;
        out_ready = 0;
        errors = 0;
        quiet = 0;
        hold_req = 0;
        in_gap = 0;
        out_gap = 0;
        mdl_key = '0;
        mdl_iv = '0;
        mdl_dec = 0;
        mdl_chain = '0;
        build_tables();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // no start flag on the first block: zero chain, zero key
        pending_blocks.push_back(mk_blk(64'h0, 64'h0, 1'b0));
        pending_blocks.push_back(mk_blk('1, '1, 1'b0));
        wait_drained();

        // FIPS-197 vector, then extremes in both directions
        write_reg(aes_pkg::REG_KEY_HIGH, 64'h0001020304050607);
        write_reg(aes_pkg::REG_KEY_LOW, 64'h08090a0b0c0d0e0f);
        write_reg(aes_pkg::REG_IV_HIGH, 64'h0);
        write_reg(aes_pkg::REG_IV_LOW, 64'h0);
        write_reg(3'd7, 64'hdead);
        pending_blocks.push_back(mk_blk(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1));
        pending_blocks.push_back(mk_blk('1, 64'h0, 1'b0));
        pending_blocks.push_back(mk_blk(64'h0, '1, 1'b0));
        wait_drained();
        write_reg(aes_pkg::REG_DECRYPT, 64'hffff_fffe);
        write_reg(aes_pkg::REG_DECRYPT, '1);
        pending_blocks.push_back(mk_blk(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b1));
        pending_blocks.push_back(mk_blk('1, '1, 1'b1));
        pending_blocks.push_back(mk_blk(64'h0, 64'h0, 1'b0));
        wait_drained();

        // key changed mid-message keeps the chain
        write_reg(aes_pkg::REG_KEY_HIGH, '1);
        write_reg(aes_pkg::REG_KEY_LOW, '1);
        write_reg(aes_pkg::REG_IV_HIGH, '1);
        write_reg(aes_pkg::REG_IV_LOW, '1);
        pending_blocks.push_back(mk_blk(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0));
        pending_blocks.push_back(mk_blk(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b1));
        wait_drained();

        // long receiver hold-off while blocks keep coming
        hold_req = 1'b1;
        for (int i = 0; i < 6; i++) pending_blocks.push_back(mk_blk(rnd64(), rnd64(), i == 0));
        wait_drained();

        // random phases: messages of random length under random settings
        for (int ph = 0; ph < 12; ph++) begin
            write_reg(aes_pkg::REG_KEY_HIGH, rnd64());
            write_reg(aes_pkg::REG_KEY_LOW, rnd64());
            write_reg(aes_pkg::REG_IV_HIGH, rnd64());
            write_reg(aes_pkg::REG_IV_LOW, rnd64());
            write_reg(aes_pkg::REG_DECRYPT, {$urandom, $urandom});
            if (ph >= 10) quiet = 1;
            n_msg = 0;
            while (n_msg < 60) begin
                int len;
                len = $urandom_range(1, 8);
                for (int j = 0; j < len; j++)
                    pending_blocks.push_back(mk_blk(rnd64(), rnd64(),
                        j == 0 ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0)));
                n_msg += len;
            end
            wait_drained();
        end

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

### files.f
+incdir+rtl
rtl/aes_pkg.sv
rtl/aes_key_ram.sv
rtl/aes128_cbc_cipher.sv
sim/tb_top.sv
